### src/fsfl_pkg.sv
// ----------------------------------------------------------------------------
// fsfl_pkg
// Shared widths, codes, reset values and types of the fixed-slot free-list
// allocator.
// ----------------------------------------------------------------------------
package fsfl_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 1024;

  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned PAYLOAD_W  = 21;
  localparam int unsigned SLOTS_W    = 11;
  localparam int unsigned SLAB_HDR_W = 13;
  localparam int unsigned ROW_HDR_W  = 9;
  localparam int unsigned STRIDE_W   = 22;
  localparam int unsigned LEAD_W     = 14;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_SLAB_BASE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAB_HEADER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_HEADER    = 3'd4;

  localparam logic [ADDR_W-1:0]     RST_SLAB_BASE  = '0;
  localparam logic [PAYLOAD_W-1:0]  RST_PAYLOAD    = 21'd64;
  localparam logic [SLOTS_W-1:0]    RST_SLOT_COUNT = 11'd1024;
  localparam logic [SLAB_HDR_W-1:0] RST_SLAB_HDR   = 13'd64;
  localparam logic [ROW_HDR_W-1:0]  RST_ROW_HDR    = 9'd32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0]     slab_base;
    logic [PAYLOAD_W-1:0]  payload_bytes;
    logic [SLOTS_W-1:0]    slot_count;
    logic [SLAB_HDR_W-1:0] slab_header_bytes;
    logic [ROW_HDR_W-1:0]  row_header_bytes;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_e              cmd;
    logic              below;
    logic [ADDR_W-1:0] offset;
  } work_t;

endpackage

### src/fsfl_if.sv
// ----------------------------------------------------------------------------
// fsfl_if
// Valid/ready channels of the allocator: command beats in, result beats out.
// ----------------------------------------------------------------------------
interface fsfl_in_if;
  logic                          valid;
  logic                          ready;
  logic [fsfl_pkg::CMD_W-1:0]    command;
  logic [fsfl_pkg::ADDR_W-1:0]   buffer_address;

  modport source (output valid, command, buffer_address, input ready);
  modport sink   (input valid, command, buffer_address, output ready);
endinterface

interface fsfl_out_if;
  logic                          valid;
  logic                          ready;
  logic [fsfl_pkg::STATUS_W-1:0] status;
  logic [fsfl_pkg::ADDR_W-1:0]   granted_address;
  logic [fsfl_pkg::INDEX_W-1:0]  slot_index;
  logic [fsfl_pkg::COUNT_W-1:0]  live_count;
  logic                          is_full;
  logic                          is_empty;

  modport source (output valid, status, granted_address, slot_index, live_count, is_full,
                  is_empty, input ready);
  modport sink   (input valid, status, granted_address, slot_index, live_count, is_full,
                  is_empty, output ready);
endinterface

### src/fsfl_front.sv
// ----------------------------------------------------------------------------
// fsfl_front
// Accepts command beats and classifies them; a free gets its offset from the
// first payload and a below-slab flag before it is queued.
// ----------------------------------------------------------------------------
module fsfl_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fsfl_pkg::cfg_t        cfg_i,
  fsfl_in_if.sink               cmd_i,
  output logic                  wr_valid_o,
  input  logic                  wr_ready_i,
  output fsfl_pkg::work_t       wr_data_o
);

  localparam int unsigned AW = fsfl_pkg::ADDR_W;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SUM,
    F_SUB,
    F_PUSH
  } front_state_e;

  front_state_e         state_q;
  fsfl_pkg::cmd_e       cmd_q;
  logic [AW-1:0]        addr_q;
  logic [AW:0]          sum_q;
  logic                 below_q;
  logic [AW-1:0]        off_q;
  logic [AW+1:0]        diff;

  assign diff = {2'b00, addr_q} - {1'b0, sum_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cmd_q   <= fsfl_pkg::CMD_NOP;
      addr_q  <= '0;
      sum_q   <= '0;
      below_q <= 1'b0;
      off_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (cmd_i.valid) begin
            cmd_q   <= fsfl_pkg::cmd_e'(cmd_i.command);
            addr_q  <= cmd_i.buffer_address;
            below_q <= 1'b0;
            off_q   <= '0;
            if (fsfl_pkg::cmd_e'(cmd_i.command) == fsfl_pkg::CMD_FREE) begin
              state_q <= F_SUM;
            end else begin
              state_q <= F_PUSH;
            end
          end
        end
        F_SUM: begin
          // first payload address, no wrap
          sum_q   <= {1'b0, cfg_i.slab_base}
                     + (AW+1)'(cfg_i.slab_header_bytes)
                     + (AW+1)'(cfg_i.row_header_bytes);
          state_q <= F_SUB;
        end
        F_SUB: begin
          below_q <= diff[AW+1];
          off_q   <= diff[AW-1:0];
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (wr_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign cmd_i.ready      = (state_q == F_IDLE);
  assign wr_valid_o       = (state_q == F_PUSH);
  assign wr_data_o.cmd    = cmd_q;
  assign wr_data_o.below  = below_q;
  assign wr_data_o.offset = off_q;

endmodule

### src/fsfl_queue.sv
// ----------------------------------------------------------------------------
// fsfl_queue
// Short queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module fsfl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  fsfl_pkg::work_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output fsfl_pkg::work_t rd_data_o
);

  localparam int unsigned DEPTH = fsfl_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  fsfl_pkg::work_t  entry_q [DEPTH];
  logic [PW-1:0]    wptr_q;
  logic [PW-1:0]    rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             push;
  logic             pop;

  assign wr_ready_o = (cnt_q != CW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= (32'(rptr_q) == DEPTH - 1) ? '0 : rptr_q + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### src/fsfl_div.sv
// ----------------------------------------------------------------------------
// fsfl_div
// Restoring divider, one quotient bit per cycle; turns a payload offset into
// a slot index and reports whether it lies on a slot boundary.
// ----------------------------------------------------------------------------
module fsfl_div #(
  parameter int unsigned IW = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [IW+fsfl_pkg::STRIDE_W-1:0] dividend_i,
  input  logic [fsfl_pkg::STRIDE_W-1:0]    divisor_i,
  output logic                            done_o,
  output logic [IW-1:0]                   quot_o,
  output logic                            exact_o
);

  localparam int unsigned RW = IW + fsfl_pkg::STRIDE_W;
  localparam int unsigned CW = $clog2(IW + 1);

  logic [RW-1:0] rem_q;
  logic [RW-1:0] dsh_q;
  logic [IW-1:0] quot_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic          ge;

  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dsh_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        rem_q  <= dividend_i;
        dsh_q  <= RW'(divisor_i) << (IW - 1);
        quot_q <= '0;
        cnt_q  <= CW'(IW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (ge) begin
          rem_q <= rem_q - dsh_q;
        end
        quot_q <= IW'({quot_q, ge});
        dsh_q  <= dsh_q >> 1;
        cnt_q  <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o  = done_q;
  assign quot_o  = quot_q;
  assign exact_o = (rem_q == '0);

endmodule

### src/fsfl_back.sv
// ----------------------------------------------------------------------------
// fsfl_back
// Carries out queued commands on the free list: link sweep for init, head
// pop with address build for alloc, range check, divide and push for free.
// Holds the link memory and the result register.
// ----------------------------------------------------------------------------
module fsfl_back #(
  parameter int unsigned MAX_SLOTS = fsfl_pkg::MAX_SLOTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fsfl_pkg::cfg_t  cfg_i,
  input  logic            rd_valid_i,
  output logic            rd_ready_o,
  input  fsfl_pkg::work_t rd_data_i,
  fsfl_out_if.source      rsp_o
);

  localparam int unsigned IW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned SW    = fsfl_pkg::STRIDE_W;
  localparam int unsigned AW    = fsfl_pkg::ADDR_W;
  localparam int unsigned NW    = fsfl_pkg::SLOTS_W;
  localparam int unsigned CNTW  = fsfl_pkg::COUNT_W;
  localparam int unsigned PW    = IW + SW;
  localparam int unsigned SUMW  = PW + 1;
  localparam int unsigned LIMW  = NW + SW;

  typedef enum logic [3:0] {
    B_IDLE,
    B_INIT,
    B_POP_RD,
    B_POP,
    B_ADD,
    B_ADDR,
    B_LIM,
    B_CHK,
    B_DIV,
    B_PUSH,
    B_RES
  } back_state_e;

  back_state_e                 state_q;
  fsfl_pkg::work_t             work_q;
  logic [IW-1:0]               head_q;
  logic                        hvalid_q;
  logic [CNTW-1:0]             count_q;
  logic [IW-1:0]               idx_q;
  logic [IW-1:0]               sweep_q;
  logic [PW-1:0]               prod_q;
  logic [SUMW-1:0]             acc_q;
  logic [LIMW-1:0]             lim_q;
  fsfl_pkg::status_e           status_q;
  logic [AW-1:0]               granted_q;
  logic [fsfl_pkg::INDEX_W-1:0] sidx_q;

  logic                        rsp_valid_q;
  logic [fsfl_pkg::STATUS_W-1:0] rsp_status_q;
  logic [AW-1:0]               rsp_granted_q;
  logic [fsfl_pkg::INDEX_W-1:0] rsp_sidx_q;
  logic [CNTW-1:0]             rsp_count_q;
  logic                        rsp_full_q;
  logic                        rsp_empty_q;

  // link memory: {has successor, successor index}
  logic [IW:0]                 link_mem [MAX_SLOTS];
  logic [IW:0]                 rdata_q;
  logic                        mem_we;
  logic [IW-1:0]               mem_waddr;
  logic [IW:0]                 mem_wdata;

  logic [NW-1:0]               n_act;
  logic [SW-1:0]               stride;
  logic [fsfl_pkg::LEAD_W-1:0] lead;
  logic                        div_start;
  logic                        div_done;
  logic [IW-1:0]               div_quot;
  logic                        div_exact;
  logic                        in_range;

  always_comb begin
    if (32'(cfg_i.slot_count) > MAX_SLOTS) begin
      n_act = NW'(MAX_SLOTS);
    end else begin
      n_act = cfg_i.slot_count;
    end
  end

  assign stride   = SW'(cfg_i.payload_bytes) + SW'(cfg_i.row_header_bytes);
  assign lead     = fsfl_pkg::LEAD_W'(cfg_i.slab_header_bytes)
                    + fsfl_pkg::LEAD_W'(cfg_i.row_header_bytes);
  assign in_range = (stride != '0) && (work_q.offset < AW'(lim_q));

  assign mem_we    = (state_q == B_INIT) || (state_q == B_PUSH);
  assign mem_waddr = (state_q == B_INIT) ? sweep_q : idx_q;
  assign mem_wdata = (state_q == B_INIT) ? {sweep_q != '0, sweep_q - IW'(1)}
                                         : {hvalid_q, head_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= link_mem[head_q];
  end

  assign div_start = (state_q == B_CHK) && in_range;

  fsfl_div #(
    .IW (IW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (work_q.offset[PW-1:0]),
    .divisor_i  (stride),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .exact_o    (div_exact)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= B_IDLE;
      work_q        <= '0;
      head_q        <= '0;
      hvalid_q      <= 1'b0;
      count_q       <= '0;
      idx_q         <= '0;
      sweep_q       <= '0;
      prod_q        <= '0;
      acc_q         <= '0;
      lim_q         <= '0;
      status_q      <= fsfl_pkg::ST_OK;
      granted_q     <= '0;
      sidx_q        <= '0;
      rsp_valid_q   <= 1'b0;
      rsp_status_q  <= '0;
      rsp_granted_q <= '0;
      rsp_sidx_q    <= '0;
      rsp_count_q   <= '0;
      rsp_full_q    <= 1'b1;
      rsp_empty_q   <= 1'b1;
    end else begin
      if (rsp_o.ready && state_q != B_RES) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (rd_valid_i) begin
            work_q    <= rd_data_i;
            status_q  <= fsfl_pkg::ST_OK;
            granted_q <= '0;
            sidx_q    <= '0;
            case (rd_data_i.cmd)
              fsfl_pkg::CMD_INIT: begin
                hvalid_q <= 1'b0;
                head_q   <= '0;
                count_q  <= '0;
                sweep_q  <= '0;
                state_q  <= (n_act == '0) ? B_RES : B_INIT;
              end
              fsfl_pkg::CMD_ALLOC: begin
                if (!hvalid_q) begin
                  status_q <= fsfl_pkg::ST_NO_SLOT;
                  state_q  <= B_RES;
                end else begin
                  idx_q   <= head_q;
                  state_q <= B_POP_RD;
                end
              end
              fsfl_pkg::CMD_FREE: begin
                if (rd_data_i.below) begin
                  status_q <= fsfl_pkg::ST_BAD_ADDR;
                  state_q  <= B_RES;
                end else begin
                  state_q <= B_LIM;
                end
              end
              default: state_q <= B_RES;
            endcase
          end
        end
        B_INIT: begin
          if (32'(sweep_q) == 32'(n_act) - 32'd1) begin
            head_q   <= sweep_q;
            hvalid_q <= 1'b1;
            state_q  <= B_RES;
          end else begin
            sweep_q <= sweep_q + IW'(1);
          end
        end
        B_POP_RD: state_q <= B_POP;
        B_POP: begin
          head_q   <= rdata_q[IW-1:0];
          hvalid_q <= rdata_q[IW];
          if (count_q != fsfl_pkg::COUNT_MAX) begin
            count_q <= count_q + CNTW'(1);
          end
          prod_q  <= PW'(idx_q) * PW'(stride);
          sidx_q  <= fsfl_pkg::INDEX_W'(idx_q);
          state_q <= B_ADD;
        end
        B_ADD: begin
          acc_q   <= SUMW'(prod_q) + SUMW'(lead);
          state_q <= B_ADDR;
        end
        B_ADDR: begin
          granted_q <= cfg_i.slab_base + AW'(acc_q);
          state_q   <= B_RES;
        end
        B_LIM: begin
          lim_q   <= LIMW'(n_act) * LIMW'(stride);
          state_q <= B_CHK;
        end
        B_CHK: begin
          if (in_range) begin
            state_q <= B_DIV;
          end else begin
            status_q <= fsfl_pkg::ST_BAD_ADDR;
            state_q  <= B_RES;
          end
        end
        B_DIV: begin
          if (div_done) begin
            if (div_exact) begin
              idx_q   <= div_quot;
              state_q <= B_PUSH;
            end else begin
              status_q <= fsfl_pkg::ST_BAD_ADDR;
              state_q  <= B_RES;
            end
          end
        end
        B_PUSH: begin
          head_q   <= idx_q;
          hvalid_q <= 1'b1;
          if (count_q != '0) begin
            count_q <= count_q - CNTW'(1);
          end
          sidx_q  <= fsfl_pkg::INDEX_W'(idx_q);
          state_q <= B_RES;
        end
        B_RES: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q   <= 1'b1;
            rsp_status_q  <= status_q;
            rsp_granted_q <= granted_q;
            rsp_sidx_q    <= sidx_q;
            rsp_count_q   <= count_q;
            rsp_full_q    <= !hvalid_q;
            rsp_empty_q   <= (count_q == '0);
            state_q       <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign rd_ready_o            = (state_q == B_IDLE);
  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_status_q;
  assign rsp_o.granted_address = rsp_granted_q;
  assign rsp_o.slot_index      = rsp_sidx_q;
  assign rsp_o.live_count      = rsp_count_q;
  assign rsp_o.is_full         = rsp_full_q;
  assign rsp_o.is_empty        = rsp_empty_q;

`ifndef ASSERT_OFF
  a_push_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_PUSH) |=> (hvalid_q && head_q == $past(idx_q)))
    else $error("push did not move the slot to the list head");

  a_no_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_RES && status_q == fsfl_pkg::ST_NO_SLOT) |-> !hvalid_q)
    else $error("no-slot result while the free list holds a slot");

  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_INIT) |-> (32'(sweep_q) < 32'(n_act)))
    else $error("init sweep beyond active slot count");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_POP && count_q != fsfl_pkg::COUNT_MAX)
      |=> (count_q == $past(count_q) + CNTW'(1)))
    else $error("allocation did not raise the live count");
`endif

endmodule

### src/fixed_slot_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// Slab allocator with a LIFO free list of equal-sized slots; links live in a
// memory, free addresses are mapped back to slot indexes by division.
//
// channel   dir  handshake                 payload
// cmd_i     in   cmd_i.valid/cmd_i.ready   command, buffer_address
// rsp_o     out  rsp_o.valid/rsp_o.ready   status, granted_address, slot_index,
//                                          live_count, is_full, is_empty
// cfg       in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// alloc pops the head and builds the address; free is range-checked, divided (one
// quotient bit per cycle) and pushed, and an unaligned free is rejected after the divide;
// init writes one link per slot, and a free may also be rejected before the divide.
// the back sequencer handles one command at a time; the front keeps taking beats
// into a two-entry queue, and a waiting result sits in the output register.
// reset empties the free list and clears the live count; link memory is not cleared.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator #(
  parameter int unsigned MAX_SLOTS = fsfl_pkg::MAX_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fsfl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fsfl_pkg::ADDR_W-1:0]      cfg_data_i,
  fsfl_in_if.sink                          cmd_i,
  fsfl_out_if.source                       rsp_o
);

  fsfl_pkg::cfg_t  cfg_q;
  logic            q_wr_valid;
  logic            q_wr_ready;
  fsfl_pkg::work_t q_wr_data;
  logic            q_rd_valid;
  logic            q_rd_ready;
  fsfl_pkg::work_t q_rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slab_base         <= fsfl_pkg::RST_SLAB_BASE;
      cfg_q.payload_bytes     <= fsfl_pkg::RST_PAYLOAD;
      cfg_q.slot_count        <= fsfl_pkg::RST_SLOT_COUNT;
      cfg_q.slab_header_bytes <= fsfl_pkg::RST_SLAB_HDR;
      cfg_q.row_header_bytes  <= fsfl_pkg::RST_ROW_HDR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fsfl_pkg::CFG_SLAB_BASE:
          cfg_q.slab_base <= cfg_data_i;
        fsfl_pkg::CFG_PAYLOAD_BYTES:
          cfg_q.payload_bytes <= cfg_data_i[fsfl_pkg::PAYLOAD_W-1:0];
        fsfl_pkg::CFG_SLOT_COUNT:
          cfg_q.slot_count <= cfg_data_i[fsfl_pkg::SLOTS_W-1:0];
        fsfl_pkg::CFG_SLAB_HEADER:
          cfg_q.slab_header_bytes <= cfg_data_i[fsfl_pkg::SLAB_HDR_W-1:0];
        fsfl_pkg::CFG_ROW_HEADER:
          cfg_q.row_header_bytes <= cfg_data_i[fsfl_pkg::ROW_HDR_W-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  fsfl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd_i),
    .wr_valid_o (q_wr_valid),
    .wr_ready_i (q_wr_ready),
    .wr_data_o  (q_wr_data)
  );

  fsfl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (q_wr_valid),
    .wr_ready_o (q_wr_ready),
    .wr_data_i  (q_wr_data),
    .rd_valid_o (q_rd_valid),
    .rd_ready_i (q_rd_ready),
    .rd_data_o  (q_rd_data)
  );

  fsfl_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .rd_valid_i (q_rd_valid),
    .rd_ready_o (q_rd_ready),
    .rd_data_i  (q_rd_data),
    .rsp_o      (rsp_o)
  );

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-slot free-list allocator. A shadow free
// list with its own link memory predicts every reply; replies are compared
// field by field in order. The run covers init, alloc, free, nop and bad-address
// frees across minimum, maximum, zero-count and zero-stride slab settings,
// under random source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_N      = int'(fsfl_pkg::MAX_SLOTS_DEF);
  localparam int QUIET_MAX  = 20000;
  localparam int LONG_HOLD  = 150;

  localparam int unsigned AW   = fsfl_pkg::ADDR_W;
  localparam int unsigned IW   = fsfl_pkg::INDEX_W;
  localparam int unsigned CNTW = fsfl_pkg::COUNT_W;
  localparam int unsigned SW   = fsfl_pkg::STRIDE_W;
  localparam int unsigned CIW  = fsfl_pkg::CFG_IDX_W;

  typedef struct packed {
    fsfl_pkg::status_e status;
    logic [AW-1:0]     granted;
    logic [IW-1:0]     index;
    logic [CNTW-1:0]   live;
    logic              full;
    logic              empty;
  } slab_reply_t;

  typedef struct {
    fsfl_pkg::cmd_e op;
    logic [AW-1:0]  addr;
    logic           drain;
  } slab_cmd_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CIW-1:0]   cfg_idx_i;
  logic [AW-1:0]    cfg_data_i;

  fsfl_in_if  cmd_if ();
  fsfl_out_if rsp_if ();

  fixed_slot_free_list_allocator uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd_if),
    .rsp_o     (rsp_if)
  );

  // shadow slab state
  fsfl_pkg::cfg_t  m_cfg;
  logic [IW-1:0]   link_next [MAX_N];
  logic            link_ok   [MAX_N];
  logic [IW-1:0]   head;
  logic            head_ok;
  logic [CNTW-1:0] live;

  slab_reply_t pending_replies [$];
  slab_cmd_t   cmd_backlog [$];
  int          trk_free [$];
  int          trk_held [$];

  int send_idle_pct;
  int recv_stall_pct;
  int phase_id;
  int held_phase;
  int hold_left;
  int quiet_cycles;
  int mismatches;
  int beats_in;
  int beats_out;
  int settings;
  int grants;
  int refusals;
  int rejects;
  int inits;

  function automatic int active_slots();
    return (m_cfg.slot_count > CNTW'(MAX_N)) ? MAX_N : int'(m_cfg.slot_count);
  endfunction

  function automatic logic [SW-1:0] slot_stride();
    return SW'(m_cfg.payload_bytes) + SW'(m_cfg.row_header_bytes);
  endfunction

  function automatic logic [AW-1:0] slot_addr(int idx);
    return m_cfg.slab_base + AW'(m_cfg.slab_header_bytes)
           + AW'(idx) * AW'(slot_stride()) + AW'(m_cfg.row_header_bytes);
  endfunction

  function automatic void predict_slab_reply(fsfl_pkg::cmd_e op, logic [AW-1:0] addr);
    slab_reply_t     r;
    logic [SW-1:0]   stride;
    logic [AW-1:0]   lead;
    logic [AW-1:0]   gap;
    logic [AW-1:0]   off;
    logic [AW-1:0]   q;
    logic [IW-1:0]   idx;
    logic            ok;
    int              n;
    r = '0;
    stride = slot_stride();
    n = active_slots();
    case (op)
      fsfl_pkg::CMD_INIT: begin
        head_ok = 1'b0;
        head = '0;
        for (int i = 0; i < n; i++) begin
          link_next[i] = head;
          link_ok[i] = head_ok;
          head = IW'(i);
          head_ok = 1'b1;
        end
        live = '0;
        inits++;
      end
      fsfl_pkg::CMD_ALLOC: begin
        if (!head_ok) begin
          r.status = fsfl_pkg::ST_NO_SLOT;
          refusals++;
        end else begin
          idx = head;
          head = link_next[idx];
          head_ok = link_ok[idx];
          if (live != fsfl_pkg::COUNT_MAX) live++;
          r.granted = slot_addr(int'(idx));
          r.index = idx;
          grants++;
        end
      end
      fsfl_pkg::CMD_FREE: begin
        ok = 1'b0;
        q = '0;
        lead = AW'(m_cfg.slab_header_bytes) + AW'(m_cfg.row_header_bytes);
        if (addr >= m_cfg.slab_base && stride != '0) begin
          gap = addr - m_cfg.slab_base;
          if (gap >= lead) begin
            off = gap - lead;
            if (off % AW'(stride) == '0) begin
              q = off / AW'(stride);
              ok = (q < AW'(n));
            end
          end
        end
        if (ok) begin
          idx = q[IW-1:0];
          link_next[idx] = head;
          link_ok[idx] = head_ok;
          head = idx;
          head_ok = 1'b1;
          if (live != '0) live--;
          r.index = idx;
        end else begin
          r.status = fsfl_pkg::ST_BAD_ADDR;
          rejects++;
        end
      end
      default: ;
    endcase
    r.live = live;
    r.full = !head_ok;
    r.empty = (live == '0);
    pending_replies.push_back(r);
  endfunction

  task automatic check_field(string name, logic [AW-1:0] want, logic [AW-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: mismatch on %s at reply %0d: expected %h, got %h",
                 name, beats_out, want, got);
    end
  endtask

  // generator-side view of the list, used only to pick meaningful addresses
  function automatic void tracker_init();
    trk_free.delete();
    trk_held.delete();
    for (int i = 0; i < active_slots(); i++) trk_free.push_back(i);
  endfunction

  function automatic logic [AW-1:0] broken_addr();
    int n;
    n = active_slots();
    case ($urandom_range(4))
      0: return {$urandom, $urandom};
      1: return slot_addr(n == 0 ? 0 : int'($urandom_range(n - 1))) + 1;
      2: return slot_addr(n + int'($urandom_range(3)));
      3: return m_cfg.slab_base - 1 - AW'($urandom_range(255));
      default: return slot_addr(0) - 1;
    endcase
  endfunction

  task automatic add_cmd(fsfl_pkg::cmd_e op, logic [AW-1:0] addr);
    cmd_backlog.push_back('{op, addr, 1'b0});
  endtask

  task automatic plan_random(int count);
    slab_cmd_t         c;
    int                k;
    int                idx;
    int                r;
    int                found [$];
    logic              filling;
    logic              do_alloc;
    filling = 1'b1;
    for (int j = 0; j < count; j++) begin
      r = $urandom_range(99);
      c.addr = {$urandom, $urandom};
      c.drain = (j == count / 2);
      if (r < 3) begin
        c.op = fsfl_pkg::CMD_INIT;
        tracker_init();
        filling = 1'b1;
      end else if (r < 8) begin
        c.op = fsfl_pkg::CMD_NOP;
      end else if (r < 14 || (r < 17 && active_slots() == 0)) begin
        c.op = fsfl_pkg::CMD_FREE;
        c.addr = broken_addr();
      end else if (r < 17) begin
        // free a slot that may already be free
        c.op = fsfl_pkg::CMD_FREE;
        idx = $urandom_range(active_slots() - 1);
        c.addr = slot_addr(idx);
        found = trk_held.find_first_index(x) with (x == idx);
        if (found.size() != 0) trk_held.delete(found[0]);
        trk_free.push_back(idx);
      end else begin
        if (trk_free.size() == 0) filling = 1'b0;
        if (trk_held.size() == 0) filling = 1'b1;
        do_alloc = trk_held.size() == 0 ||
                   ($urandom_range(99) < (filling ? 75 : 25));
        if (do_alloc) begin
          c.op = fsfl_pkg::CMD_ALLOC;
          if (trk_free.size() != 0) trk_held.push_back(trk_free.pop_back());
        end else begin
          c.op = fsfl_pkg::CMD_FREE;
          k = $urandom_range(trk_held.size() - 1);
          idx = trk_held[k];
          trk_held.delete(k);
          trk_free.push_back(idx);
          c.addr = slot_addr(idx);
        end
      end
      cmd_backlog.push_back(c);
    end
  endtask

  task automatic write_reg(logic [CIW-1:0] idx, logic [AW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      fsfl_pkg::CFG_SLAB_BASE:     m_cfg.slab_base = val;
      fsfl_pkg::CFG_PAYLOAD_BYTES: m_cfg.payload_bytes = val[fsfl_pkg::PAYLOAD_W-1:0];
      fsfl_pkg::CFG_SLOT_COUNT:    m_cfg.slot_count = val[fsfl_pkg::SLOTS_W-1:0];
      fsfl_pkg::CFG_SLAB_HEADER:
        m_cfg.slab_header_bytes = val[fsfl_pkg::SLAB_HDR_W-1:0];
      fsfl_pkg::CFG_ROW_HEADER:
        m_cfg.row_header_bytes = val[fsfl_pkg::ROW_HDR_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_slab(logic [AW-1:0] base, logic [AW-1:0] payload,
                          logic [AW-1:0] slots, logic [AW-1:0] hdr,
                          logic [AW-1:0] row);
    write_reg(fsfl_pkg::CFG_SLAB_BASE, base);
    write_reg(fsfl_pkg::CFG_PAYLOAD_BYTES, payload);
    write_reg(fsfl_pkg::CFG_SLOT_COUNT, slots);
    write_reg(fsfl_pkg::CFG_SLAB_HEADER, hdr);
    write_reg(fsfl_pkg::CFG_ROW_HEADER, row);
    settings++;
  endtask

  task automatic set_idle(int mode);
    case (mode)
      1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
      3:       begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || pending_replies.size() != 0 || cmd_if.valid)
      @(posedge clk_i);
  endtask

  task automatic run_phase(int mode, int count);
    phase_id++;
    set_idle(mode);
    cmd_backlog.push_back('{fsfl_pkg::CMD_INIT, {$urandom, $urandom}, 1'b0});
    tracker_init();
    plan_random(count - 1);
    wait_drained();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // command driver
  always @(posedge clk_i) begin
    slab_cmd_t nxt;
    logic      busy;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      busy = cmd_if.valid;
      if (cmd_if.valid && cmd_if.ready) begin
        predict_slab_reply(fsfl_pkg::cmd_e'(cmd_if.command), cmd_if.buffer_address);
        beats_in++;
        busy = 1'b0;
      end
      if (!busy && cmd_backlog.size() != 0 &&
          !(cmd_backlog[0].drain && pending_replies.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = cmd_backlog.pop_front();
        cmd_if.command        <= nxt.op;
        cmd_if.buffer_address <= nxt.addr;
        busy = 1'b1;
      end
      cmd_if.valid <= busy;
    end
  end

  // reply monitor
  always @(posedge clk_i) begin
    slab_reply_t got;
    slab_reply_t want;
    logic        nr;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.status  = fsfl_pkg::status_e'(rsp_if.status);
        got.granted = rsp_if.granted_address;
        got.index   = rsp_if.slot_index;
        got.live    = rsp_if.live_count;
        got.full    = rsp_if.is_full;
        got.empty   = rsp_if.is_empty;
        if (pending_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: reply beat with nothing expected: %p", got);
        end else begin
          want = pending_replies.pop_front();
          check_field("status", AW'(want.status), AW'(got.status));
          check_field("granted_address", want.granted, got.granted);
          check_field("slot_index", AW'(want.index), AW'(got.index));
          check_field("live_count", AW'(want.live), AW'(got.live));
          check_field("is_full", AW'(want.full), AW'(got.full));
          check_field("is_empty", AW'(want.empty), AW'(got.empty));
        end
        beats_out++;
        if ((phase_id == 3 || phase_id == 9) && held_phase != phase_id) begin
          held_phase = phase_id;
          hold_left = LONG_HOLD;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else begin
        nr = $urandom_range(99) >= recv_stall_pct;
      end
      rsp_if.ready <= nr;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cmd_backlog.size() == 0 && pending_replies.size() == 0 && !cmd_if.valid)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = fsfl_pkg::CFG_SLAB_BASE;
    cfg_data_i            = '0;
    cmd_if.valid          = 1'b0;
    cmd_if.command        = fsfl_pkg::CMD_NOP;
    cmd_if.buffer_address = '0;
    rsp_if.ready          = 1'b0;
    m_cfg = '{fsfl_pkg::RST_SLAB_BASE, fsfl_pkg::RST_PAYLOAD, fsfl_pkg::RST_SLOT_COUNT,
              fsfl_pkg::RST_SLAB_HDR, fsfl_pkg::RST_ROW_HDR};
    head = '0;
    head_ok = 1'b0;
    live = '0;
    held_phase = 0;
    hold_left = 0;
    quiet_cycles = 0;
    mismatches = 0;
    beats_in = 0;
    beats_out = 0;
    settings = 0;
    grants = 0;
    refusals = 0;
    rejects = 0;
    inits = 0;
    phase_id = 1;
    set_idle(0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset defaults
    add_cmd(fsfl_pkg::CMD_ALLOC, '0);
    add_cmd(fsfl_pkg::CMD_FREE, slot_addr(5));
    add_cmd(fsfl_pkg::CMD_ALLOC, '0);
    add_cmd(fsfl_pkg::CMD_ALLOC, '0);
    add_cmd(fsfl_pkg::CMD_NOP, '1);
    add_cmd(fsfl_pkg::CMD_INIT, '0);
    add_cmd(fsfl_pkg::CMD_ALLOC, '0);
    add_cmd(fsfl_pkg::CMD_ALLOC, '0);
    add_cmd(fsfl_pkg::CMD_FREE, slot_addr(MAX_N - 1));
    add_cmd(fsfl_pkg::CMD_FREE, slot_addr(MAX_N - 1));
    add_cmd(fsfl_pkg::CMD_FREE, '0);
    add_cmd(fsfl_pkg::CMD_FREE, slot_addr(0) - 1);
    add_cmd(fsfl_pkg::CMD_FREE, slot_addr(0) + 1);
    add_cmd(fsfl_pkg::CMD_FREE, slot_addr(MAX_N));
    add_cmd(fsfl_pkg::CMD_FREE, '1);
    add_cmd(fsfl_pkg::CMD_FREE, slot_addr(0));
    add_cmd(fsfl_pkg::CMD_FREE, slot_addr(0));
    add_cmd(fsfl_pkg::CMD_ALLOC, '1);
    add_cmd(fsfl_pkg::CMD_ALLOC, '0);
    add_cmd(fsfl_pkg::CMD_INIT, '1);
    wait_drained();

    set_slab(64'h1000, 1, 1, 0, 0);
    run_phase(1, 80);
    set_slab(64'hFFFF_FFFF_C000_0000, 1048576, 1024, 4096, 256);
    run_phase(2, 100);
    set_slab({$urandom, $urandom}, 64, 0, 64, 32);
    run_phase(3, 30);
    set_slab(64'h8000, 0, 6, 128, 0);
    run_phase(0, 30);
    set_slab({$urandom, $urandom}, $urandom_range(1, 64), 2047, $urandom_range(4096),
             $urandom_range(256));
    run_phase(1, 120);
    for (int p = 0; p < 6; p++) begin
      set_slab({$urandom, $urandom},
               ($urandom_range(3) == 0) ? $urandom_range(1, 1048576) : $urandom_range(1, 512),
               (p == 2) ? 1500 : $urandom_range(1, 24),
               $urandom_range(4096), $urandom_range(256));
      run_phase(p % 4, 110);
    end

    repeat (30) @(posedge clk_i);
    $display("tb: %0d command beats and %0d reply beats over %0d slab settings",
             beats_in, beats_out, settings);
    $display("tb: %0d inits, %0d grants, %0d refused allocs, %0d rejected frees",
             inits, grants, refusals, rejects);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/fsfl_pkg.sv
src/fsfl_if.sv
src/fsfl_front.sv
src/fsfl_queue.sv
src/fsfl_div.sv
src/fsfl_back.sv
src/fixed_slot_free_list_allocator.sv
tb/tb.sv
